// ===== hw/rtl/fqke_pkg.sv =====
// Package for the key-extract FIFO queue: default sizes, codes and sequencer states.
package fqke_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam logic [1:0] MODE_PUSH    = 2'd0;
  localparam logic [1:0] MODE_POP     = 2'd1;
  localparam logic [1:0] MODE_EXTRACT = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_MISS = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_SCAN,
    ST_CMP,
    ST_MV_RD,
    ST_MV_WR,
    ST_DONE
  } fqke_state_t;

endpackage

// ===== hw/rtl/fqke_ram.sv =====
// Generic simple dual-port RAM with registered read.
module fqke_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fifo_queue_with_key_extract.sv =====
// Top level: bounded FIFO queue with push, pop and extract-by-key.
//
//  channel  | handshake          | payload
//  ---------+--------------------+------------------------------------------
//  request  | start, busy        | mode, entry_key, entry_value
//  result   | done (one strobe)  | status, hit, out_key, out_value, count
//
// Entries sit in a circular buffer in one RAM; a sequencer drives its single
// read and write port. Push writes the new entry behind the newest. Pop and
// extract scan from the oldest entry until the key matches (pop takes the
// oldest), then move each older entry up one place to close the gap.
// A miss on an empty queue goes straight to the result.
// Reset (rst, synchronous) empties the queue; the RAM needs no clearing.
// Results are never stalled: done is high for exactly one cycle.
module fifo_queue_with_key_extract
  import fqke_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int KEY_WIDTH   = KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   mode,
  input  logic [KEY_WIDTH-1:0]         entry_key,
  input  logic [VALUE_WIDTH-1:0]       entry_value,
  output logic                         done,
  output logic [1:0]                   status,
  output logic                         hit,
  output logic [KEY_WIDTH-1:0]         out_key,
  output logic [VALUE_WIDTH-1:0]       out_value,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int EW = KEY_WIDTH + VALUE_WIDTH;
  localparam logic [AW:0]   DEPTH_A = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  fqke_state_t state, state_next;

  logic [AW-1:0]          head;
  logic [CW-1:0]          cnt;
  logic [AW-1:0]          idx;
  logic [1:0]             op;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] val_r;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [KEY_WIDTH-1:0]   rd_key;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic                   match;
  logic                   last;

  function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
    logic [AW:0] t;
    t = (s >= DEPTH_A) ? s - DEPTH_A : s;
    return t[AW-1:0];
  endfunction

  fqke_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_key = ram_rdata[EW-1:VALUE_WIDTH];
  assign rd_val = ram_rdata[VALUE_WIDTH-1:0];
  assign match  = (op == MODE_POP) || (rd_key == key_r);
  assign last   = ((CW'(idx) + CW'(1)) == cnt);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          unique case (mode)
            MODE_PUSH:    state_next = (cnt == DEPTH_C) ? ST_DONE : ST_PUSH;
            MODE_POP,
            MODE_EXTRACT: state_next = (cnt == '0) ? ST_DONE : ST_SCAN;
            default:      state_next = ST_DONE;
          endcase
        end
      end
      ST_PUSH:  state_next = ST_DONE;
      ST_SCAN:  state_next = ST_CMP;
      ST_CMP: begin
        if (match) begin
          state_next = (idx == '0) ? ST_DONE : ST_MV_RD;
        end else if (last) begin
          state_next = ST_DONE;
        end
      end
      ST_MV_RD: state_next = ST_MV_WR;
      ST_MV_WR: state_next = (idx == AW'(1)) ? ST_DONE : ST_MV_RD;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and RAM control
  always_comb begin
    busy      = (state != ST_IDLE);
    done      = (state == ST_DONE);
    ram_we    = 1'b0;
    ram_waddr = wrap({1'b0, head} + (AW + 1)'(cnt[AW-1:0]));
    ram_wdata = {key_r, val_r};
    ram_raddr = wrap({1'b0, head} + {1'b0, idx});
    unique case (state)
      ST_PUSH: begin
        ram_we = 1'b1;
      end
      ST_CMP: begin
        ram_raddr = wrap({1'b0, head} + {1'b0, idx} + (AW + 1)'(1));
      end
      ST_MV_RD: begin
        ram_raddr = wrap({1'b0, head} + {1'b0, idx} - (AW + 1)'(1));
      end
      ST_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wrap({1'b0, head} + {1'b0, idx});
        ram_wdata = ram_rdata;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      head  <= '0;
      cnt   <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          idx <= '0;
        end
        ST_PUSH: begin
          cnt <= cnt + CW'(1);
        end
        ST_CMP: begin
          if (match) begin
            if (idx == '0) begin
              head <= wrap({1'b0, head} + (AW + 1)'(1));
              cnt  <= cnt - CW'(1);
            end
          end else if (!last) begin
            idx <= idx + AW'(1);
          end
        end
        ST_MV_WR: begin
          idx <= idx - AW'(1);
          if (idx == AW'(1)) begin
            head <= wrap({1'b0, head} + (AW + 1)'(1));
            cnt  <= cnt - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          op        <= mode;
          key_r     <= entry_key;
          val_r     <= entry_value;
          hit       <= 1'b0;
          out_key   <= '0;
          out_value <= '0;
          unique case (mode)
            MODE_PUSH:    status <= (cnt == DEPTH_C) ? STAT_FULL : STAT_OK;
            MODE_POP,
            MODE_EXTRACT: status <= (cnt == '0) ? STAT_MISS : STAT_OK;
            default:      status <= STAT_OK;
          endcase
        end
      end
      ST_CMP: begin
        if (match) begin
          hit       <= 1'b1;
          out_key   <= rd_key;
          out_value <= rd_val;
          status    <= STAT_OK;
        end else if (last) begin
          status <= STAT_MISS;
        end
      end
      default: begin
      end
    endcase
  end

  assign count = cnt;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= DEPTH_C)
    else $error("entry count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    state == ST_PUSH |=> cnt == $past(cnt) + CW'(1))
    else $error("push did not add one entry");

  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    done && hit |-> status == STAT_OK)
    else $error("removed entry reported with bad status");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !hit |-> out_key == '0 && out_value == '0)
    else $error("no entry removed but payload nonzero");

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("sequencer did not return to idle after result");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for the key-extract FIFO queue: directed and random requests checked against a queue model.
module tb_top;
  import fqke_pkg::*;

  localparam int KW = KEY_WIDTH_DEF;
  localparam int VW = VALUE_WIDTH_DEF;
  localparam int CW = $clog2(DEPTH_DEF + 1);
  localparam logic [1:0] MODE_NONE = 2'd3;
  localparam int TAIL_CYCLES = 3 * DEPTH_DEF + 16;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 600;

  typedef struct packed {
    logic [KW-1:0] key;
    logic [VW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [1:0]    status;
    logic          hit;
    logic [KW-1:0] key;
    logic [VW-1:0] value;
    logic [CW-1:0] count;
  } outcome_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic [1:0]    mode = MODE_PUSH;
  logic [KW-1:0] entry_key = '0;
  logic [VW-1:0] entry_value = '0;
  logic          busy;
  logic          done;
  logic [1:0]    status;
  logic          hit;
  logic [KW-1:0] out_key;
  logic [VW-1:0] out_value;
  logic [CW-1:0] count;

  entry_t   held[$];
  outcome_t pending_results[$];
  int       errors = 0;
  int       cycles = 0;

  fifo_queue_with_key_extract u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .mode        (mode),
    .entry_key   (entry_key),
    .entry_value (entry_value),
    .done        (done),
    .status      (status),
    .hit         (hit),
    .out_key     (out_key),
    .out_value   (out_value),
    .count       (count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic outcome_t apply_request(input logic [1:0] m, input logic [KW-1:0] k,
                                             input logic [VW-1:0] v);
    outcome_t r;
    entry_t   e;
    r = '0;
    r.status = STAT_OK;
    case (m)
      MODE_PUSH: begin
        if (held.size() >= DEPTH_DEF) begin
          r.status = STAT_FULL;
        end else begin
          e.key = k;
          e.value = v;
          held.push_back(e);
        end
      end
      MODE_POP: begin
        if (held.size() == 0) begin
          r.status = STAT_MISS;
        end else begin
          e = held.pop_front();
          r.hit = 1'b1;
          r.key = e.key;
          r.value = e.value;
        end
      end
      MODE_EXTRACT: begin
        r.status = STAT_MISS;
        for (int i = 0; i < held.size(); i++) begin
          if (held[i].key == k) begin
            r.status = STAT_OK;
            r.hit = 1'b1;
            r.key = held[i].key;
            r.value = held[i].value;
            held.delete(i);
            break;
          end
        end
      end
      default: ;
    endcase
    r.count = CW'(held.size());
    return r;
  endfunction

  always @(posedge clk) begin
    outcome_t exp_r;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: result with no request pending: st=%0d hit=%0b key=%h val=%h cnt=%0d",
                   $time, status, hit, out_key, out_value, count);
      end else begin
        exp_r = pending_results.pop_front();
        if (status !== exp_r.status || hit !== exp_r.hit || out_key !== exp_r.key ||
            out_value !== exp_r.value || count !== exp_r.count) begin
          errors++;
          if (errors <= 10)
            $display("%0t: mismatch exp st=%0d hit=%0b key=%h val=%h cnt=%0d, got st=%0d hit=%0b key=%h val=%h cnt=%0d",
                     $time, exp_r.status, exp_r.hit, exp_r.key, exp_r.value, exp_r.count,
                     status, hit, out_key, out_value, count);
        end
      end
    end
  end

  task automatic send_request(input logic [1:0] m, input logic [KW-1:0] k,
                              input logic [VW-1:0] v, input int idle_pct);
    start <= 1'b1;
    mode <= m;
    entry_key <= k;
    entry_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_request(m, k, v));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(20, 60)) @(posedge clk);
      else
        repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_request(MODE_POP, 16'h0000, 32'h0, 0);
    send_request(MODE_EXTRACT, 16'h0000, 32'h0, 0);
    send_request(MODE_NONE, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send_request(MODE_PUSH, 16'h0000, 32'h0000_0000, 0);
    send_request(MODE_PUSH, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send_request(MODE_PUSH, 16'h1234, 32'hAAAA_5555, 0);
    send_request(MODE_PUSH, 16'h1234, 32'h5555_AAAA, 0);
    for (int i = 0; i < DEPTH_DEF - 4; i++)
      send_request(MODE_PUSH, KW'(16'h0100 + i), $urandom, 0);
    // queue full: dropped push, then oldest of duplicate keys
    send_request(MODE_PUSH, 16'h4321, 32'h1111_2222, 0);
    send_request(MODE_EXTRACT, 16'h1234, 32'h0, 0);
    send_request(MODE_EXTRACT, 16'h5555, 32'h0, 0);
    send_request(MODE_NONE, 16'h0000, 32'h0, 0);
    send_request(MODE_POP, 16'hFFFF, 32'hFFFF_FFFF, 0);
    send_request(MODE_EXTRACT, KW'(16'h0100 + DEPTH_DEF - 5), 32'h0, 0);
    wait_drained();
  endtask

  task automatic run_random(input int n, input int idle_pct);
    logic [1:0]    m;
    logic [KW-1:0] k;
    int            r;
    int            push_w;
    for (int i = 0; i < n; i++) begin
      push_w = ((i / 40) % 2 == 0) ? 65 : 25;
      r = $urandom_range(0, 99);
      if (r < 5)
        m = MODE_NONE;
      else if (r < 5 + push_w)
        m = MODE_PUSH;
      else if ($urandom_range(0, 99) < 40)
        m = MODE_POP;
      else
        m = MODE_EXTRACT;
      if ($urandom_range(0, 99) < 60)
        k = KW'($urandom_range(0, 7));
      else
        k = KW'($urandom);
      if (m == MODE_EXTRACT && held.size() != 0 && $urandom_range(0, 99) < 70)
        k = held[$urandom_range(0, held.size() - 1)].key;
      send_request(m, k, $urandom, idle_pct);
      if (i % 150 == 149)
        wait_drained();
    end
    wait_drained();
  endtask

  task automatic test_random_no_idle();
    run_random(PHASE_ITEMS, 0);
  endtask

  task automatic test_random_sender_idle();
    run_random(PHASE_ITEMS, 80);
  endtask

  task automatic test_random_mixed_idle();
    run_random(PHASE_ITEMS, 28);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_mixed_idle();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    errors += pending_results.size();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
